FILE: rtl/mph_pkg.sv
// ----------------------------------------------------------------------------
// mph_pkg
// Shared types and constants for the min-heap priority queue core.
// ----------------------------------------------------------------------------
package mph_pkg;

	localparam int KEY_W        = 32;
	localparam int TAG_W        = 16;
	localparam int STATUS_W     = 2;
	localparam int CNT_OUT_W    = 5;
	localparam int CAPACITY_DEF = 16;

	// operation codes
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic        [TAG_W-1:0] tag;
	} entry_t;

endpackage

FILE: rtl/mph_ram.sv
// ----------------------------------------------------------------------------
// mph_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mph_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

FILE: rtl/min_heap_priority_queue_core.sv
// ----------------------------------------------------------------------------
// min_heap_priority_queue_core
// Binary min-heap of (key, tag) entries with push and pop-minimum requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The heap lives in a
// two-read RAM. A small sequencer walks one heap level at a time: a RAM read,
// then a compare and write back through the key comparators.
// While busy is high after the request is taken, the sequencer does:
//   - push into an empty heap: the final write only;
//   - push: a read and a compare per parent, and a final write when the
//     entry climbs to the root;
//   - pop: a fetch of the root and the last entry, then a read and a compare
//     per level (a pop of the only entry takes just the fetch).
// The worst case is a pop that sinks to the bottom. Pop on an empty heap and
// push on a full one hold busy for one cycle, return an error status and
// leave the heap untouched. The result shows for exactly one cycle with done
// high, in the same cycle that busy drops; there is no way to hold it, so
// capture it then. A new request may be taken in that cycle.
module min_heap_priority_queue_core
	import mph_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       func,
	input  logic signed [KEY_W-1:0]    push_key,
	input  logic        [TAG_W-1:0]    push_tag,
	output logic                       done,
	output logic signed [KEY_W-1:0]    out_key,
	output logic        [TAG_W-1:0]    out_tag,
	output logic        [STATUS_W-1:0] status,
	output logic        [CNT_OUT_W-1:0] count_after
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = IDX_W + 2;

	typedef enum logic [3:0] {
		S_IDLE, S_UP_RD, S_UP_CMP, S_PLACE, S_POP_RD, S_POP_LD,
		S_DN_RD, S_DN_CMP, S_FIN
	} state_t;

	state_t                  state_q;
	logic                    busy_q;
	logic                    done_q;
	logic [CNT_W-1:0]        count_q;
	logic [IDX_W-1:0]        pos_q;
	entry_t                  item_q;
	logic signed [KEY_W-1:0] out_key_q;
	logic [TAG_W-1:0]        out_tag_q;
	logic [STATUS_W-1:0]     status_q;
	logic [CNT_OUT_W-1:0]    count_after_q;

	logic                    wr_en;
	logic [IDX_W-1:0]        wr_addr;
	entry_t                  wr_data;
	logic [IDX_W-1:0]        rd_addr_a;
	logic [IDX_W-1:0]        rd_addr_b;
	entry_t                  rd_a;
	entry_t                  rd_b;

	logic [IDX_W-1:0]        parent_idx;
	logic [CMP_W-1:0]        lc_ext;
	logic [CMP_W-1:0]        rc_ext;
	logic [CMP_W-1:0]        cnt_ext;
	logic                    lc_ok;
	logic                    rc_ok;
	logic                    up_less;
	logic                    take_l;
	logic                    take_r;
	logic signed [KEY_W-1:0] best_key;
	logic [IDX_W-1:0]        child_idx;
	entry_t                  child_ent;
	logic                    finish;
	logic                    accept;

	mph_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (CAPACITY)
	) u_heap_ram (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (wr_addr),
		.wdata   (wr_data),
		.raddr_a (rd_addr_a),
		.raddr_b (rd_addr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	assign accept = start && !busy_q;

	// child and parent indexes, and the key compares
	always_comb begin
		parent_idx = IDX_W'((pos_q - 1'b1) >> 1);
		lc_ext     = {1'b0, pos_q, 1'b1};
		rc_ext     = lc_ext + 1'b1;
		cnt_ext    = CMP_W'(count_q);
		lc_ok      = lc_ext < cnt_ext;
		rc_ok      = rc_ext < cnt_ext;
		up_less    = item_q.key < rd_a.key;
		take_l     = lc_ok && (rd_a.key < item_q.key);
		best_key   = take_l ? rd_a.key : item_q.key;
		take_r     = rc_ok && (rd_b.key < best_key);
		child_idx  = take_r ? rc_ext[IDX_W-1:0] : lc_ext[IDX_W-1:0];
		child_ent  = take_r ? rd_b : rd_a;
	end

	always_comb begin
		rd_addr_a = '0;
		rd_addr_b = '0;
		wr_en     = 1'b0;
		wr_addr   = pos_q;
		wr_data   = item_q;
		finish    = 1'b0;
		case (state_q)
			S_UP_RD: begin
				rd_addr_a = parent_idx;
			end
			S_UP_CMP: begin
				wr_en = 1'b1;
				if (up_less) begin
					wr_data = rd_a;
				end else begin
					finish = 1'b1;
				end
			end
			S_PLACE: begin
				wr_en  = 1'b1;
				finish = 1'b1;
			end
			S_POP_RD: begin
				rd_addr_b = count_q[IDX_W-1:0];
			end
			S_POP_LD: begin
				finish = (count_q == '0);
			end
			S_DN_RD: begin
				rd_addr_a = lc_ext[IDX_W-1:0];
				rd_addr_b = rc_ext[IDX_W-1:0];
			end
			S_DN_CMP: begin
				wr_en = 1'b1;
				if (take_l || take_r) begin
					wr_data = child_ent;
				end else begin
					finish = 1'b1;
				end
			end
			S_FIN: begin
				finish = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			busy_q        <= 1'b0;
			done_q        <= 1'b0;
			count_q       <= '0;
			pos_q         <= '0;
			item_q        <= '0;
			out_key_q     <= '0;
			out_tag_q     <= '0;
			count_after_q <= '0;
			status_q      <= ST_OK;
		end else begin
			done_q <= finish;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						busy_q    <= 1'b1;
						out_key_q <= '0;
						out_tag_q <= '0;
						item_q    <= '{key: push_key, tag: push_tag};
						if (func == FUNC_PUSH) begin
							if (count_q == CNT_W'(CAPACITY)) begin
								status_q <= ST_FULL;
								state_q  <= S_FIN;
							end else begin
								status_q <= ST_OK;
								pos_q    <= count_q[IDX_W-1:0];
								count_q  <= count_q + 1'b1;
								state_q  <= (count_q == '0) ? S_PLACE : S_UP_RD;
							end
						end else begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
								state_q  <= S_FIN;
							end else begin
								status_q <= ST_OK;
								count_q  <= count_q - 1'b1;
								state_q  <= S_POP_RD;
							end
						end
					end
				end
				S_UP_RD: begin
					state_q <= S_UP_CMP;
				end
				S_UP_CMP: begin
					if (up_less) begin
						pos_q   <= parent_idx;
						state_q <= (parent_idx == '0) ? S_PLACE : S_UP_RD;
					end
				end
				S_POP_RD: begin
					state_q <= S_POP_LD;
				end
				S_POP_LD: begin
					// root goes out, last entry becomes the hole's occupant
					out_key_q <= rd_a.key;
					out_tag_q <= rd_a.tag;
					item_q    <= rd_b;
					pos_q     <= '0;
					if (count_q != '0) begin
						state_q <= S_DN_RD;
					end
				end
				S_DN_RD: begin
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (take_l || take_r) begin
						pos_q   <= child_idx;
						state_q <= S_DN_RD;
					end
				end
				default: begin
				end
			endcase
			if (finish) begin
				state_q       <= S_IDLE;
				busy_q        <= 1'b0;
				count_after_q <= CNT_OUT_W'(count_q);
			end
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign out_key     = out_key_q;
	assign out_tag     = out_tag_q;
	assign status      = status_q;
	assign count_after = count_after_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("request taken but core not busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!busy_q && state_q == S_IDLE))
		else $error("done while sequencer active");

	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> done_q)
		else $error("request finished without result");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != ST_OK) |-> (out_key_q == '0 && out_tag_q == '0))
		else $error("error result carries payload");

	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (CNT_W'(wr_addr) < count_q))
		else $error("heap write beyond held entries");

endmodule
